FILE: design/dldr_pkg.sv
// ----------------------------------------------------------------------------
// dldr_pkg - delay line Doppler rotator shared definitions
// Sizes, lane types, control bundle and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package dldr_pkg;

   localparam int HIST_DEPTH = 65536;
   localparam int ANTENNAS   = 2;
   localparam int LANES_MAX  = 2;
   localparam int ADDR_W     = $clog2(HIST_DEPTH);
   localparam int CNT_W      = $clog2(HIST_DEPTH) + 1;
   localparam int SAMPLE_W   = 16;
   localparam int DELAY_W    = 20;
   localparam int PHASE_W    = 32;
   localparam int PROD_W     = 2 * SAMPLE_W;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] im;
      logic signed [SAMPLE_W-1:0] re;
   } dldr_iq_type;

   typedef struct packed {
      logic              accept;
      logic              advance;
      logic [ADDR_W-1:0] wr_addr;
      logic [ADDR_W-1:0] rd_addr;
      logic              bypass;
      logic              hit1;
   } dldr_ctrl_type;

   localparam logic [14:0] QUARTER_SINE [65] = '{
      15'd0,     15'd804,   15'd1608,  15'd2410,  15'd3212,  15'd4011,  15'd4808,
      15'd5602,  15'd6393,  15'd7179,  15'd7962,  15'd8739,  15'd9512,  15'd10278,
      15'd11039, 15'd11793, 15'd12539, 15'd13279, 15'd14010, 15'd14732, 15'd15446,
      15'd16151, 15'd16846, 15'd17530, 15'd18204, 15'd18868, 15'd19519, 15'd20159,
      15'd20787, 15'd21403, 15'd22005, 15'd22594, 15'd23170, 15'd23731, 15'd24279,
      15'd24811, 15'd25329, 15'd25832, 15'd26319, 15'd26790, 15'd27245, 15'd27683,
      15'd28105, 15'd28510, 15'd28898, 15'd29268, 15'd29621, 15'd29956, 15'd30273,
      15'd30571, 15'd30852, 15'd31113, 15'd31356, 15'd31580, 15'd31785, 15'd31971,
      15'd32137, 15'd32285, 15'd32412, 15'd32521, 15'd32609, 15'd32678, 15'd32728,
      15'd32757, 15'd32767
   };

   // sine of idx/256 turn, Q1.15
   function automatic logic signed [SAMPLE_W-1:0] table_sin(input logic [7:0] idx);
      logic [6:0]  r;
      logic [14:0] mag;
      r = {1'b0, idx[5:0]};
      if (idx[6]) begin
         mag = QUARTER_SINE[7'd64 - r];
      end else begin
         mag = QUARTER_SINE[r];
      end
      if (idx[7]) begin
         return -$signed({1'b0, mag});
      end
      return $signed({1'b0, mag});
   endfunction

endpackage

FILE: design/dldr_if.sv
// ----------------------------------------------------------------------------
// dldr_req_if / dldr_rsp_if - sample and result channels
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface dldr_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] re_ant0;
   logic signed [15:0] im_ant0;
   logic signed [15:0] re_ant1;
   logic signed [15:0] im_ant1;
   logic        [19:0] delay_samples;
   logic signed [31:0] phase_inc;
   logic               restart;

   modport source (output valid, re_ant0, im_ant0, re_ant1, im_ant1,
                   delay_samples, phase_inc, restart, input ready);
   modport sink   (input valid, re_ant0, im_ant0, re_ant1, im_ant1,
                   delay_samples, phase_inc, restart, output ready);
endinterface

interface dldr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] out_re_ant0;
   logic signed [15:0] out_im_ant0;
   logic signed [15:0] out_re_ant1;
   logic signed [15:0] out_im_ant1;
   logic               history_hit;

   modport source (output valid, out_re_ant0, out_im_ant0, out_re_ant1,
                   out_im_ant1, history_hit, input ready);
   modport sink   (input valid, out_re_ant0, out_im_ant0, out_re_ant1,
                   out_im_ant1, history_hit, output ready);
endinterface

FILE: design/dldr_lane.sv
// ----------------------------------------------------------------------------
// dldr_lane - one antenna lane
// History ring memory, delayed read with bypass, complex rotation, round/sat.
// ----------------------------------------------------------------------------
module dldr_lane import dldr_pkg::*; (
   input  logic                       clock,
   input  dldr_ctrl_type              ctrl,
   input  dldr_iq_type                sample,
   input  logic signed [SAMPLE_W-1:0] sin1,
   input  logic signed [SAMPLE_W-1:0] cos1,
   output dldr_iq_type                result
);

   logic [2*SAMPLE_W-1:0] mem [HIST_DEPTH];
   logic [2*SAMPLE_W-1:0] rdata_ff;
   dldr_iq_type           smp_ff;
   logic                  byp_ff;
   dldr_iq_type           x;
   logic signed [PROD_W-1:0] rc_ff, is_ff, rs_ff, ic_ff;
   logic signed [PROD_W:0]   sum_re, sum_im;

   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         mem[ctrl.wr_addr] <= sample;
         rdata_ff          <= mem[ctrl.rd_addr];
         smp_ff            <= sample;
         byp_ff            <= ctrl.bypass;
      end
   end

   always_comb begin
      if (!ctrl.hit1) begin
         x = '0;
      end else if (byp_ff) begin
         x = smp_ff;
      end else begin
         x = dldr_iq_type'(rdata_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         rc_ff <= x.re * cos1;
         is_ff <= x.im * sin1;
         rs_ff <= x.re * sin1;
         ic_ff <= x.im * cos1;
      end
   end

   function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [PROD_W:0] v);
      logic signed [PROD_W:0] b;
      logic signed [PROD_W:0] y;
      b = v + (PROD_W+1)'(16384);
      y = b >>> 15;
      if (y > (PROD_W+1)'(32767)) begin
         return 16'sh7fff;
      end else if (y < -(PROD_W+1)'(32768)) begin
         return 16'sh8000;
      end
      return y[SAMPLE_W-1:0];
   endfunction

   assign sum_re = (PROD_W+1)'(rc_ff) - (PROD_W+1)'(is_ff);
   assign sum_im = (PROD_W+1)'(rs_ff) + (PROD_W+1)'(ic_ff);
   assign result.re = round_sat(sum_re);
   assign result.im = round_sat(sum_im);

endmodule

FILE: design/dldr_merge.sv
// ----------------------------------------------------------------------------
// dldr_merge - result merge and output register
// Collects the lane results and the hit flag into one result beat.
// ----------------------------------------------------------------------------
module dldr_merge import dldr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           valid2,
   input  logic           hit2,
   input  dldr_iq_type    lanes [LANES_MAX],
   output logic           advance,
   dldr_rsp_if.source     rsp_ch
);

   logic        valid_ff;
   logic        hit_ff;
   dldr_iq_type out_ff [LANES_MAX];

   assign advance = !valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid2;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hit_ff <= hit2;
         out_ff <= lanes;
      end
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.history_hit = hit_ff;
   assign rsp_ch.out_re_ant0 = out_ff[0].re;
   assign rsp_ch.out_im_ant0 = out_ff[0].im;
   assign rsp_ch.out_re_ant1 = out_ff[1].re;
   assign rsp_ch.out_im_ant1 = out_ff[1].im;

endmodule

FILE: design/delay_line_doppler_rotator_core.sv
// ----------------------------------------------------------------------------
// delay_line_doppler_rotator_core - variable delay line with NCO rotation
// Per-antenna history lanes with a shared phase accumulator and merge stage.
//
//   channel  dir  beat contents
//   req_ch   in   four IQ words, delay, phase step, restart
//   rsp_ch   out  four rotated IQ words, history hit
//
// One beat per cycle sustained while rsp_ch is ready; accept to rsp_ch passes
// the ring read register, one multiply stage per lane and the merge register.
// Reset clears write pointer, history count and phase; memory is not cleared.
// A stall on rsp_ch holds the whole pipeline and drops req_ch.ready.
// ----------------------------------------------------------------------------
module delay_line_doppler_rotator_core import dldr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   dldr_req_if.sink   req_ch,
   dldr_rsp_if.source rsp_ch
);

   logic [ADDR_W-1:0]  wp_ff;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [PHASE_W-1:0] acc_ff, acc_plus;
   logic               v1_ff, v2_ff, hit1_ff, hit2_ff;
   logic signed [SAMPLE_W-1:0] sin1_ff, cos1_ff;
   logic               advance, accept, hit0;
   logic [7:0]         idx;
   dldr_ctrl_type      ctrl;
   dldr_iq_type        samples [LANES_MAX];
   dldr_iq_type        lanes [LANES_MAX];

   assign accept = req_ch.valid && advance;
   assign req_ch.ready = advance;

   always_comb begin
      if (req_ch.restart) begin
         cnt_in = CNT_W'(1);
      end else if (cnt_ff < CNT_W'(HIST_DEPTH)) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else begin
         cnt_in = cnt_ff;
      end
   end

   assign hit0     = 32'(req_ch.delay_samples) < 32'(cnt_in);
   assign acc_plus = acc_ff + PHASE_W'(32'h0080_0000);
   assign idx      = acc_plus[PHASE_W-1 -: 8];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         cnt_ff <= '0;
         acc_ff <= '0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
      end else begin
         if (accept) begin
            wp_ff  <= wp_ff + ADDR_W'(1);
            cnt_ff <= cnt_in;
            acc_ff <= acc_ff + PHASE_W'(req_ch.phase_inc);
         end
         if (advance) begin
            v1_ff <= accept;
            v2_ff <= v1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hit1_ff <= hit0;
         sin1_ff <= table_sin(idx);
         cos1_ff <= table_sin(idx + 8'd64);
      end
      if (advance) begin
         hit2_ff <= hit1_ff;
      end
   end

   assign ctrl.accept  = accept;
   assign ctrl.advance = advance;
   assign ctrl.wr_addr = wp_ff;
   assign ctrl.rd_addr = wp_ff - req_ch.delay_samples[ADDR_W-1:0];
   assign ctrl.bypass  = req_ch.delay_samples == '0;
   assign ctrl.hit1    = hit1_ff;

   assign samples[0].re = req_ch.re_ant0;
   assign samples[0].im = req_ch.im_ant0;
   assign samples[1].re = req_ch.re_ant1;
   assign samples[1].im = req_ch.im_ant1;

   for (genvar a = 0; a < LANES_MAX; a++) begin : g_lane
      if (a < ANTENNAS) begin : g_on
         dldr_lane u_lane (
            .clock  (clock),
            .ctrl   (ctrl),
            .sample (samples[a]),
            .sin1   (sin1_ff),
            .cos1   (cos1_ff),
            .result (lanes[a])
         );
      end else begin : g_off
         assign lanes[a] = '0;
      end
   end

   dldr_merge u_merge (
      .clock   (clock),
      .reset   (reset),
      .valid2  (v2_ff),
      .hit2    (hit2_ff),
      .lanes   (lanes),
      .advance (advance),
      .rsp_ch  (rsp_ch)
   );

   a_restart_count: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.restart |=> cnt_ff == CNT_W'(1))
      else $error("history count not reset by restart");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(HIST_DEPTH))
      else $error("history count above depth");

   a_wp_step: assert property (@(posedge clock) disable iff (reset)
      accept |=> wp_ff == $past(wp_ff) + ADDR_W'(1))
      else $error("write pointer did not advance");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.history_hit |->
         rsp_ch.out_re_ant0 == '0 && rsp_ch.out_im_ant0 == '0 &&
         rsp_ch.out_re_ant1 == '0 && rsp_ch.out_im_ant1 == '0)
      else $error("nonzero output on history miss");

   a_bypass_hit: assert property (@(posedge clock) disable iff (reset)
      accept && ctrl.bypass |-> hit0)
      else $error("zero delay read missed history");

endmodule

FILE: test/dldr_tb_pkg.sv
// ----------------------------------------------------------------------------
// dldr_tb_pkg - delay line Doppler rotator scoreboard
// Beat types for both channels and a scoreboard that keeps its own copy of
// the ring history, valid count and phase, works out the rotated output for
// every accepted sample beat and checks result beats against it in order.
// ----------------------------------------------------------------------------
package dldr_tb_pkg;
   import dldr_pkg::*;

   typedef struct packed {
      logic signed [15:0] re0;
      logic signed [15:0] im0;
      logic signed [15:0] re1;
      logic signed [15:0] im1;
      logic        [19:0] delay;
      logic signed [31:0] step;
      logic               restart;
   } sample_beat_type;

   typedef struct packed {
      logic signed [15:0] re0;
      logic signed [15:0] im0;
      logic signed [15:0] re1;
      logic signed [15:0] im1;
      logic               hit;
   } rotated_beat_type;

   class delay_rotation_scoreboard;
      dldr_iq_type        ring [ANTENNAS][HIST_DEPTH];
      int unsigned        wr_slot;
      int unsigned        valid_count;
      logic [31:0]        phase;
      rotated_beat_type   expected_q [$];
      int unsigned        samples_seen;
      int unsigned        results_seen;
      int unsigned        hits_seen;
      int unsigned        mismatches;

      function new();
         wr_slot      = 0;
         valid_count  = 0;
         phase        = '0;
         samples_seen = 0;
         results_seen = 0;
         hits_seen    = 0;
         mismatches   = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // sine of idx/256 turn, Q1.15
      function int sine_of(bit [7:0] idx);
         int mag;
         if (idx[6]) begin
            mag = int'(QUARTER_SINE[64 - idx[5:0]]);
         end else begin
            mag = int'(QUARTER_SINE[idx[5:0]]);
         end
         return idx[7] ? -mag : mag;
      endfunction

      // round half up, then clamp to int16
      function logic signed [15:0] round_sat(longint acc);
         longint y;
         y = (acc + 64'sd16384) >>> 15;
         if (y > 32767) begin
            return 16'sh7FFF;
         end
         if (y < -32768) begin
            return 16'sh8000;
         end
         return 16'(y);
      endfunction

      function void note_sample(sample_beat_type b);
         rotated_beat_type   r;
         logic signed [15:0] out_re [2];
         logic signed [15:0] out_im [2];
         dldr_iq_type        x;
         int unsigned        rd;
         bit [7:0]           idx;
         int                 c;
         int                 s;
         samples_seen++;
         if (b.restart) begin
            valid_count = 0;
         end
         for (int a = 0; a < ANTENNAS; a++) begin
            if (a == 0) begin
               ring[a][wr_slot] = {b.im0, b.re0};
            end else begin
               ring[a][wr_slot] = {b.im1, b.re1};
            end
         end
         if (valid_count < HIST_DEPTH) begin
            valid_count++;
         end
         r     = '0;
         r.hit = (b.delay < valid_count);
         idx   = 8'((phase + 32'h0080_0000) >> 24);
         s     = sine_of(idx);
         c     = sine_of(idx + 8'd64);
         for (int a = 0; a < 2; a++) begin
            out_re[a] = '0;
            out_im[a] = '0;
         end
         if (r.hit) begin
            rd = (wr_slot + HIST_DEPTH - b.delay) % HIST_DEPTH;
            for (int a = 0; a < ANTENNAS; a++) begin
               x = ring[a][rd];
               out_re[a] = round_sat(longint'(x.re) * c - longint'(x.im) * s);
               out_im[a] = round_sat(longint'(x.re) * s + longint'(x.im) * c);
            end
         end
         r.re0 = out_re[0];
         r.im0 = out_im[0];
         r.re1 = out_re[1];
         r.im1 = out_im[1];
         expected_q.push_back(r);
         wr_slot = (wr_slot + 1) % HIST_DEPTH;
         phase   = phase + b.step;
      endfunction

      function void compare_field(string label, logic signed [31:0] want,
                                  logic signed [31:0] got, time stamp);
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 40) begin
               $display("%0d ns: %s mismatch, expected %0d, actual %0d",
                        stamp, label, want, got);
            end
         end
      endfunction

      function void check_result(rotated_beat_type got, time stamp);
         rotated_beat_type want;
         results_seen++;
         if (got.hit === 1'b1) begin
            hits_seen++;
         end
         if (expected_q.size() == 0) begin
            mismatches++;
            $display("%0d ns: result beat with none expected, actual %0d %0d %0d %0d hit %0d",
                     stamp, got.re0, got.im0, got.re1, got.im1, got.hit);
            return;
         end
         want = expected_q.pop_front();
         compare_field("out_re_ant0", want.re0, got.re0, stamp);
         compare_field("out_im_ant0", want.im0, got.im0, stamp);
         compare_field("out_re_ant1", want.re1, got.re1, stamp);
         compare_field("out_im_ant1", want.im1, got.im1, stamp);
         compare_field("history_hit", want.hit, got.hit, stamp);
      endfunction
   endclass

endpackage

FILE: test/delay_line_doppler_rotator_core_tb.sv
// ----------------------------------------------------------------------------
// delay_line_doppler_rotator_core_tb - delay line Doppler rotator testbench
// Directed beats for saturation, table quadrants, phase wrap, restart and
// out-of-history delays, then random sample streams with random gaps on both
// channels and one long result back-pressure stretch, then one unbroken
// back-to-back burst with the result side always ready.
// ----------------------------------------------------------------------------
module delay_line_doppler_rotator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dldr_pkg::*;
   import dldr_tb_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 2_000_000;
   localparam int          RANDOM_ITEMS = 700;
   localparam int          BURST_ITEMS  = 180;
   localparam int          HOLD_AT      = 300;
   localparam int          HOLD_CYCLES  = 400;
   localparam int          DRAIN_CYCLES = 16;

   logic clock;
   logic reset;

   dldr_req_if req_ch ();
   dldr_rsp_if rsp_ch ();

   delay_line_doppler_rotator_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   delay_rotation_scoreboard rotation_sb;
   int unsigned since_restart;
   bit          sender_idles;
   bit          receiver_idles;
   bit          hold_done;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("FAILED: results differ");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
         rotation_sb.note_sample('{re0: req_ch.re_ant0, im0: req_ch.im_ant0,
                                   re1: req_ch.re_ant1, im1: req_ch.im_ant1,
                                   delay: req_ch.delay_samples,
                                   step: req_ch.phase_inc,
                                   restart: req_ch.restart});
      end
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         rotation_sb.check_result('{re0: rsp_ch.out_re_ant0, im0: rsp_ch.out_im_ant0,
                                    re1: rsp_ch.out_re_ant1, im1: rsp_ch.out_im_ant1,
                                    hit: rsp_ch.history_hit}, $time);
      end
   end

   function automatic int pick_gap(int long_max);
      if ($urandom_range(0, 9) < 8) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, long_max);
   endfunction

   // result side: random stalls, plus one long hold-off to back up the pipe
   initial begin
      int gap_left;
      int hold_left;
      gap_left = 0;
      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(posedge clock);
         if (!hold_done && rotation_sb.results_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            hold_left = HOLD_CYCLES;
            while (hold_left > 0) begin
               @(posedge clock);
               hold_left--;
            end
         end else if (gap_left > 0) begin
            rsp_ch.ready <= 1'b0;
            gap_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (receiver_idles && $urandom_range(0, 7) == 0) begin
               gap_left = pick_gap(40);
            end
         end
      end
   end

   function automatic logic signed [15:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic signed [31:0] pick_step();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
         2: return {8'($urandom_range(0, 255)), 24'h000000};
         3: return 32'h7FFF_FFFF;
         default: return 32'h8000_0000;
      endcase
   endfunction

   // delays mostly inside the valid history, some right at its edge
   function automatic logic [19:0] pick_delay(bit restart);
      int unsigned avail;
      avail = restart ? 1 : since_restart + 1;
      if (avail > HIST_DEPTH) begin
         avail = HIST_DEPTH;
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return 20'($urandom_range(0, avail - 1));
         6: return 20'(avail);
         7: return 20'(avail - 1);
         8: return 20'($urandom_range(0, 20'hFFFFF));
         default: return 20'($urandom_range(0, 15));
      endcase
   endfunction

   function automatic sample_beat_type make_sample(bit restart, logic signed [31:0] step);
      sample_beat_type b;
      b.re0     = pick_word();
      b.im0     = pick_word();
      b.re1     = pick_word();
      b.im1     = pick_word();
      b.delay   = pick_delay(restart);
      b.step    = step;
      b.restart = restart;
      return b;
   endfunction

   task automatic push_sample(input sample_beat_type b);
      int gap;
      req_ch.valid         <= 1'b1;
      req_ch.re_ant0       <= b.re0;
      req_ch.im_ant0       <= b.im0;
      req_ch.re_ant1       <= b.re1;
      req_ch.im_ant1       <= b.im1;
      req_ch.delay_samples <= b.delay;
      req_ch.phase_inc     <= b.step;
      req_ch.restart       <= b.restart;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) begin
         @(posedge clock);
      end
      since_restart = b.restart ? 1 : since_restart + 1;
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         gap = pick_gap(40);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_fields(input int re0, input int im0, input int re1, input int im1,
                              input logic [19:0] delay, input logic [31:0] step,
                              input bit restart);
      sample_beat_type b;
      b.re0     = 16'(re0);
      b.im0     = 16'(im0);
      b.re1     = 16'(re1);
      b.im1     = 16'(im1);
      b.delay   = delay;
      b.step    = step;
      b.restart = restart;
      push_sample(b);
   endtask

   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (rotation_sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      logic signed [31:0] step;
      int                 sent;
      int                 stream_len;
      bit                 first_restart;
      bit                 restart_bit;
      rotation_sb          = new();
      since_restart        = 0;
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.re_ant0       <= '0;
      req_ch.im_ant0       <= '0;
      req_ch.re_ant1       <= '0;
      req_ch.im_ant1       <= '0;
      req_ch.delay_samples <= '0;
      req_ch.phase_inc     <= '0;
      req_ch.restart       <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;

      // saturation at 45 degrees, quadrants, wrap, rounding edge, restarts
      send_fields( 32767, -32768, -32768,  32767, 20'd0, 32'h2000_0000, 1'b1);
      send_fields(-32768, -32768,  32767,  32767, 20'd0, 32'h2000_0000, 1'b0);
      send_fields(     0,      0,      0,      0, 20'd1, 32'h2000_0000, 1'b0);
      send_fields(     1,     -1,     -1,      1, 20'd3, 32'h2000_0000, 1'b0);
      send_fields( 16384, -16384,  12345, -23456, 20'd5, 32'h4000_0000, 1'b0);
      send_fields(    -1,      1,  32767, -32768, 20'hFFFFF, 32'h4000_0000, 1'b0);
      send_fields(  1000,   2000,  -3000,   4000, 20'd4, 32'h4000_0000, 1'b0);
      send_fields( 32767,  32767, -32768, -32768, 20'd0, 32'h7FFF_FFFF, 1'b0);
      send_fields( -2222,   3333,  -4444,   5555, 20'd2, 32'h8000_0000, 1'b0);
      send_fields(  7777,  -8888,   9999, -11111, 20'd0, 32'hFFFF_FFFF, 1'b0);
      send_fields( 20000,  20000, -20000, -20000, 20'd1, 32'h0080_0000, 1'b0);
      send_fields(-32768,  32767,  32767, -32768, 20'd0, 32'h007F_FFFF, 1'b0);
      send_fields(   123,   -456,    789,  -1011, 20'd0, 32'h0100_0000, 1'b1);
      send_fields(  -321,    654,   -987,   1101, 20'd1, 32'hFF00_0000, 1'b0);
      send_fields(   111,    222,    333,    444, 20'd2, 32'h1234_5678, 1'b0);
      send_fields(   555,    666,    777,    888, 20'd1, 32'h0, 1'b1);
      send_fields(-32768, -32768, -32768, -32768, 20'd0, 32'h0, 1'b1);
      send_fields(     0,      0,      0,      0, 20'd1, 32'h0, 1'b0);
      wait_for_results();

      // restart-framed streams with random content and a few stray restarts
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         stream_len     = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 40);
         first_restart  = ($urandom_range(0, 7) != 0);
         step           = pick_step();
         sender_idles   = ($urandom_range(0, 3) != 0);
         receiver_idles = ($urandom_range(0, 3) != 0);
         for (int k = 0; k < stream_len && sent < RANDOM_ITEMS; k++) begin
            restart_bit = (k == 0) ? first_restart : ($urandom_range(0, 63) == 0);
            if ($urandom_range(0, 15) == 0) begin
               step = pick_step();
            end
            push_sample(make_sample(restart_bit, step));
            sent++;
         end
      end
      wait_for_results();

      // one unbroken back-to-back burst, result side always ready
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      step           = pick_step();
      for (int k = 0; k < BURST_ITEMS; k++) begin
         if ($urandom_range(0, 31) == 0) begin
            step = pick_step();
         end
         push_sample(make_sample(k == 0, step));
      end
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d sample beats: directed corners, restart-framed random streams",
               rotation_sb.samples_seen);
      $display("and one unbroken burst; %0d results checked, %0d from history, %0d zero-filled.",
               rotation_sb.results_seen, rotation_sb.hits_seen,
               rotation_sb.results_seen - rotation_sb.hits_seen);
      if (rotation_sb.mismatches == 0 && rotation_sb.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
